### rtl/core/sri_pkg.sv
// Shared widths, constants and handshake structs for the strided range intersect block.
`timescale 1ns / 1ps
package sri_pkg;

    localparam int CW       = 16;
    localparam int SW       = 32;
    localparam int TW       = CW + 2;
    localparam int CNT_BITS = 6;

    localparam logic [CNT_BITS-1:0] DIV_SHORT_STEPS = CNT_BITS'(CW);
    localparam logic [CNT_BITS-1:0] DIV_LONG_STEPS  = CNT_BITS'(SW);

    typedef struct packed {
        logic          start;
        logic          long_div;
        logic [SW-1:0] dividend;
        logic [CW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic          done;
        logic [SW-1:0] quotient;
        logic [CW-1:0] remainder;
    } div_rsp_t;

    typedef struct packed {
        logic [CW-1:0] first;
        logic [CW-1:0] last;
        logic [SW-1:0] stride;
        logic          empty;
    } sri_res_t;

endpackage

### rtl/core/sri_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, shared by the sequencer.
`timescale 1ns / 1ps
module sri_div (
    input  logic              clk,
    input  logic              rst_n,
    input  sri_pkg::div_req_t req,
    output sri_pkg::div_rsp_t rsp
);

    logic                         busy_reg;
    logic                         done_reg;
    logic [sri_pkg::CNT_BITS-1:0] cnt_reg;
    logic [sri_pkg::SW-1:0]       quo_reg;
    logic [sri_pkg::CW-1:0]       rem_reg;
    logic [sri_pkg::CW-1:0]       dvs_reg;

    logic [sri_pkg::CW:0] trial;
    logic [sri_pkg::CW:0] diff;
    logic                 ge;

    assign trial = {rem_reg, quo_reg[sri_pkg::SW-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= req.long_div ? sri_pkg::DIV_LONG_STEPS : sri_pkg::DIV_SHORT_STEPS;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == sri_pkg::CNT_BITS'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.long_div ? req.dividend
                                    : {req.dividend[sri_pkg::CW-1:0], {sri_pkg::CW{1'b0}}};
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[sri_pkg::CW-1:0] : trial[sri_pkg::CW-1:0];
            quo_reg <= {quo_reg[sri_pkg::SW-2:0], ge};
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

### rtl/core/sri_seq.sv
// Sequencer: extended Euclid, CRT solve and window trim over the shared divider.
`timescale 1ns / 1ps
module sri_seq (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [sri_pkg::CW-1:0] first_a,
    input  logic [sri_pkg::CW-1:0] last_a,
    input  logic [sri_pkg::CW-1:0] stride_a,
    input  logic [sri_pkg::CW-1:0] first_b,
    input  logic [sri_pkg::CW-1:0] last_b,
    input  logic [sri_pkg::CW-1:0] stride_b,
    output sri_pkg::div_req_t      div_req,
    input  sri_pkg::div_rsp_t      div_rsp,
    output logic                   res_valid,
    input  logic                   res_ready,
    output sri_pkg::sri_res_t      res
);

    typedef enum logic [4:0] {
        S_IDLE, S_EU, S_MQ, S_GC, S_RA, S_FB, S_RB, S_DQ, S_KS, S_KD,
        S_WIN, S_GP, S_GAPC, S_LS, S_LW, S_LC, S_OUT
    } state_t;

    state_t state_reg;

    logic [sri_pkg::CW-1:0]        fa_reg, fb_reg, sa_reg, sb_reg;
    logic [sri_pkg::CW-1:0]        maxf_reg, minl_reg, diff_reg;
    logic [sri_pkg::CW-1:0]        r1_reg, g_reg, m_reg, inv_reg;
    logic [sri_pkg::CW-1:0]        r_reg, d_reg, tmp_reg, first_reg, last_reg;
    logic signed [sri_pkg::TW-1:0] t0_reg, t1_reg;
    logic [sri_pkg::SW-1:0]        lcm_reg, kprod_reg, x_reg;
    logic                          empty_reg;

    logic [sri_pkg::CW-1:0]        fa_in, la_in, fb_in, lb_in, sa_fix, sb_fix;
    logic signed [sri_pkg::TW-1:0] mul_a, mul_b;
    logic signed [2*sri_pkg::TW-1:0] mul_p;
    logic signed [sri_pkg::TW-1:0] t_new;
    logic [sri_pkg::TW-1:0]        inv_v, inv_calc;
    logic [sri_pkg::CW:0]          d_sum;
    logic [sri_pkg::CW-1:0]        d_calc;
    logic [sri_pkg::CW-1:0]        q16, rem16;
    logic [sri_pkg::CW-1:0]        gap_dvd, last_dvd, room;
    logic [sri_pkg::SW-1:0]        gap;
    logic                          lcm_big, win_bad, x_ge, x_gt, done;

    assign done  = div_rsp.done;
    assign q16   = div_rsp.quotient[sri_pkg::CW-1:0];
    assign rem16 = div_rsp.remainder;

    assign fa_in  = (first_a <= last_a) ? first_a : last_a;
    assign la_in  = (first_a <= last_a) ? last_a : first_a;
    assign fb_in  = (first_b <= last_b) ? first_b : last_b;
    assign lb_in  = (first_b <= last_b) ? last_b : first_b;
    assign sa_fix = (stride_a == '0) ? sri_pkg::CW'(1) : stride_a;
    assign sb_fix = (stride_b == '0) ? sri_pkg::CW'(1) : stride_b;

    assign mul_p = mul_a * mul_b;
    assign t_new = t0_reg - mul_p[sri_pkg::TW-1:0];

    assign inv_v    = t0_reg + (t0_reg[sri_pkg::TW-1] ? {2'b00, m_reg} : '0);
    assign inv_calc = (inv_v >= {2'b00, m_reg}) ? (inv_v - {2'b00, m_reg}) : inv_v;

    assign d_sum  = {1'b0, d_reg} + {1'b0, sb_reg} - {1'b0, rem16};
    assign d_calc = (d_sum >= {1'b0, sb_reg}) ? (d_sum[sri_pkg::CW-1:0] - sb_reg)
                                              : d_sum[sri_pkg::CW-1:0];

    assign lcm_big  = |lcm_reg[sri_pkg::SW-1:sri_pkg::CW];
    assign win_bad  = minl_reg < maxf_reg;
    assign x_ge     = x_reg >= {{(sri_pkg::SW-sri_pkg::CW){1'b0}}, maxf_reg};
    assign x_gt     = x_reg > {{(sri_pkg::SW-sri_pkg::CW){1'b0}}, minl_reg};
    assign gap_dvd  = maxf_reg - x_reg[sri_pkg::CW-1:0];
    assign last_dvd = minl_reg - first_reg;
    assign room     = minl_reg - maxf_reg;
    assign gap      = (tmp_reg == '0) ? '0
                    : (lcm_reg - {{(sri_pkg::SW-sri_pkg::CW){1'b0}}, tmp_reg});

    always_comb
    begin
        div_req = '0;
        mul_a   = '0;
        mul_b   = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                div_req.start    = in_valid;
                div_req.dividend = sri_pkg::SW'(sb_fix);
                div_req.divisor  = sa_fix;
            end
            S_EU:
            begin
                mul_a         = t1_reg;
                mul_b         = signed'({2'b00, q16});
                div_req.start = done;
                if (rem16 != '0)
                begin
                    div_req.dividend = sri_pkg::SW'(r1_reg);
                    div_req.divisor  = rem16;
                end
                else
                begin
                    div_req.dividend = sri_pkg::SW'(sb_reg);
                    div_req.divisor  = r1_reg;
                end
            end
            S_MQ:
            begin
                mul_a            = signed'({2'b00, sa_reg});
                mul_b            = signed'({2'b00, q16});
                div_req.start    = done;
                div_req.dividend = sri_pkg::SW'(diff_reg);
                div_req.divisor  = g_reg;
            end
            S_GC:
            begin
                div_req.start    = done && (rem16 == '0);
                div_req.dividend = sri_pkg::SW'(fa_reg);
                div_req.divisor  = sa_reg;
            end
            S_RA:
            begin
                div_req.start    = done;
                div_req.dividend = sri_pkg::SW'(fb_reg);
                div_req.divisor  = sb_reg;
            end
            S_FB:
            begin
                div_req.start    = done;
                div_req.dividend = sri_pkg::SW'(r_reg);
                div_req.divisor  = sb_reg;
            end
            S_RB:
            begin
                div_req.start    = done;
                div_req.dividend = sri_pkg::SW'(d_calc);
                div_req.divisor  = g_reg;
            end
            S_DQ:
            begin
                mul_a = signed'({2'b00, q16});
                mul_b = signed'({2'b00, inv_reg});
            end
            S_KS:
            begin
                div_req.start    = 1'b1;
                div_req.long_div = 1'b1;
                div_req.dividend = kprod_reg;
                div_req.divisor  = m_reg;
            end
            S_KD:
            begin
                mul_a = signed'({2'b00, sa_reg});
                mul_b = signed'({2'b00, rem16});
            end
            S_WIN:
            begin
                div_req.start    = !win_bad && !x_ge && !lcm_big;
                div_req.dividend = sri_pkg::SW'(gap_dvd);
                div_req.divisor  = lcm_reg[sri_pkg::CW-1:0];
            end
            S_LS:
            begin
                div_req.start    = !lcm_big;
                div_req.dividend = sri_pkg::SW'(last_dvd);
                div_req.divisor  = lcm_reg[sri_pkg::CW-1:0];
            end
            S_GP, S_GAPC, S_LW, S_LC, S_OUT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        fa_reg    <= fa_in;
                        fb_reg    <= fb_in;
                        sa_reg    <= sa_fix;
                        sb_reg    <= sb_fix;
                        maxf_reg  <= (fa_in > fb_in) ? fa_in : fb_in;
                        minl_reg  <= (la_in < lb_in) ? la_in : lb_in;
                        diff_reg  <= (fa_in > fb_in) ? (fa_in - fb_in) : (fb_in - fa_in);
                        r1_reg    <= sa_fix;
                        t0_reg    <= '0;
                        t1_reg    <= sri_pkg::TW'(1);
                        empty_reg <= 1'b0;
                        state_reg <= S_EU;
                    end
                end
                S_EU:
                begin
                    if (done)
                    begin
                        t0_reg <= t1_reg;
                        t1_reg <= t_new;
                        if (rem16 != '0)
                        begin
                            r1_reg <= rem16;
                        end
                        else
                        begin
                            g_reg     <= r1_reg;
                            state_reg <= S_MQ;
                        end
                    end
                end
                S_MQ:
                begin
                    if (done)
                    begin
                        m_reg     <= q16;
                        lcm_reg   <= mul_p[sri_pkg::SW-1:0];
                        state_reg <= S_GC;
                    end
                end
                S_GC:
                begin
                    inv_reg <= inv_calc[sri_pkg::CW-1:0];
                    if (done)
                    begin
                        if (rem16 != '0)
                        begin
                            empty_reg <= 1'b1;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_RA;
                        end
                    end
                end
                S_RA:
                begin
                    if (done)
                    begin
                        r_reg     <= rem16;
                        state_reg <= S_FB;
                    end
                end
                S_FB:
                begin
                    if (done)
                    begin
                        d_reg     <= rem16;
                        state_reg <= S_RB;
                    end
                end
                S_RB:
                begin
                    if (done)
                    begin
                        state_reg <= S_DQ;
                    end
                end
                S_DQ:
                begin
                    if (done)
                    begin
                        kprod_reg <= mul_p[sri_pkg::SW-1:0];
                        state_reg <= S_KS;
                    end
                end
                S_KS:
                begin
                    state_reg <= S_KD;
                end
                S_KD:
                begin
                    if (done)
                    begin
                        x_reg     <= sri_pkg::SW'(r_reg) + mul_p[sri_pkg::SW-1:0];
                        state_reg <= S_WIN;
                    end
                end
                S_WIN:
                begin
                    priority if (win_bad)
                    begin
                        empty_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else if (x_ge)
                    begin
                        if (x_gt)
                        begin
                            empty_reg <= 1'b1;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            first_reg <= x_reg[sri_pkg::CW-1:0];
                            state_reg <= S_LS;
                        end
                    end
                    else if (lcm_big)
                    begin
                        tmp_reg   <= gap_dvd;
                        state_reg <= S_GAPC;
                    end
                    else
                    begin
                        state_reg <= S_GP;
                    end
                end
                S_GP:
                begin
                    if (done)
                    begin
                        tmp_reg   <= rem16;
                        state_reg <= S_GAPC;
                    end
                end
                S_GAPC:
                begin
                    if (gap > sri_pkg::SW'(room))
                    begin
                        empty_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        first_reg <= maxf_reg + gap[sri_pkg::CW-1:0];
                        state_reg <= S_LS;
                    end
                end
                S_LS:
                begin
                    if (lcm_big)
                    begin
                        tmp_reg   <= last_dvd;
                        state_reg <= S_LC;
                    end
                    else
                    begin
                        state_reg <= S_LW;
                    end
                end
                S_LW:
                begin
                    if (done)
                    begin
                        tmp_reg   <= rem16;
                        state_reg <= S_LC;
                    end
                end
                S_LC:
                begin
                    last_reg  <= minl_reg - tmp_reg;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_OUT);
    assign res.first  = empty_reg ? sri_pkg::CW'(1) : first_reg;
    assign res.last   = empty_reg ? '0 : last_reg;
    assign res.stride = lcm_reg;
    assign res.empty  = empty_reg;

endmodule

### rtl/core/strided_range_intersect.sv
// Top level: sequencer, shared divider and the output holding register.
//
// Usage: present two strided ranges (first, last, stride for A and B) on the
// input channel with in_valid; a transfer happens when in_valid and in_ready
// are both high. Bounds may come in either order and are swapped internally.
// One result transfers on the output channel: the shared range (out_first,
// out_last, out_stride as the lcm of both strides) and is_empty. An empty
// result reports out_first 1 and out_last 0, with out_stride still the lcm.
// One item is worked on at a time; in_ready is low while it runs. Nearly all
// of the work goes to the radix-2 divider: n steps of extended Euclid, then up
// to eight more short divisions and the one 32-step division, where n is the
// number of Euclid steps on the two strides (1 to about 24 for 16-bit strides).
// A residue mismatch ends after the Euclid steps and two more divisions.
// The finished result sits in an output register, so the next item is taken
// while it waits. When the receiver stalls with that register still full,
// the sequencer holds its next result until the register frees up.
// Reset clears the sequencer, the divider and out_valid; no clearing pass.
`timescale 1ns / 1ps
module strided_range_intersect (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [sri_pkg::CW-1:0] first_a,
    input  logic [sri_pkg::CW-1:0] last_a,
    input  logic [sri_pkg::CW-1:0] stride_a,
    input  logic [sri_pkg::CW-1:0] first_b,
    input  logic [sri_pkg::CW-1:0] last_b,
    input  logic [sri_pkg::CW-1:0] stride_b,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [sri_pkg::CW-1:0] out_first,
    output logic [sri_pkg::CW-1:0] out_last,
    output logic [sri_pkg::SW-1:0] out_stride,
    output logic                   is_empty
);

    sri_pkg::div_req_t div_req;
    sri_pkg::div_rsp_t div_rsp;
    sri_pkg::sri_res_t res;
    logic              res_valid;
    logic              res_ready;

    logic                   out_valid_reg;
    logic [sri_pkg::CW-1:0] out_first_reg;
    logic [sri_pkg::CW-1:0] out_last_reg;
    logic [sri_pkg::SW-1:0] out_stride_reg;
    logic                   is_empty_reg;

    sri_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .first_a   (first_a),
        .last_a    (last_a),
        .stride_a  (stride_a),
        .first_b   (first_b),
        .last_b    (last_b),
        .stride_b  (stride_b),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    sri_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_first_reg  <= res.first;
            out_last_reg   <= res.last;
            out_stride_reg <= res.stride;
            is_empty_reg   <= res.empty;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_first  = out_first_reg;
    assign out_last   = out_last_reg;
    assign out_stride = out_stride_reg;
    assign is_empty   = is_empty_reg;

endmodule

### rtl/core/sri_checker.sv
// Port-level checks for the strided range intersect block, bound to the top level.
`timescale 1ns / 1ps
module sri_port_checks (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [sri_pkg::CW-1:0] out_first,
    input logic [sri_pkg::CW-1:0] out_last,
    input logic [sri_pkg::SW-1:0] out_stride,
    input logic                   is_empty
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_first)
            && $stable(out_last) && $stable(out_stride) && $stable(is_empty))
        else $error("output transfer dropped or changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again while an item is in progress");

    a_empty_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_empty |-> out_first == sri_pkg::CW'(1) && out_last == '0)
        else $error("empty result not reported as first 1, last 0");

    a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_empty |-> out_first <= out_last)
        else $error("non-empty result with first above last");

    a_stride_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_stride != '0)
        else $error("result stride is zero");

endmodule

bind strided_range_intersect sri_port_checks u_sri_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_first  (out_first),
    .out_last   (out_last),
    .out_stride (out_stride),
    .is_empty   (is_empty)
);

### sim/sri_checker.sv
// Checker for the strided range intersect block: predicts each result and compares it.
`timescale 1ns / 1ps
module sri_checker
    import sri_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_ready,
    input  logic [CW-1:0] first_a,
    input  logic [CW-1:0] last_a,
    input  logic [CW-1:0] stride_a,
    input  logic [CW-1:0] first_b,
    input  logic [CW-1:0] last_b,
    input  logic [CW-1:0] stride_b,
    input  logic          out_valid,
    input  logic          out_ready,
    input  logic [CW-1:0] out_first,
    input  logic [CW-1:0] out_last,
    input  logic [SW-1:0] out_stride,
    input  logic          is_empty,
    output int            err_count,
    output int            pending
);

    sri_res_t    shared_q[$];
    sri_res_t    want;
    int unsigned result_idx;

    function automatic longint unsigned gcd_of(longint unsigned m, longint unsigned n);
        longint unsigned t;
        while (n != 0)
        begin
            t = m % n;
            m = n;
            n = t;
        end
        return m;
    endfunction

    // Inverse of a modulo m via extended Euclid; a and m coprime.
    function automatic longint unsigned inverse_mod(longint unsigned a, longint unsigned m);
        longint r0;
        longint r1;
        longint s0;
        longint s1;
        longint q;
        longint t;
        if (m <= 1)
            return 0;
        r0 = $signed(m);
        r1 = $signed(a % m);
        s0 = 0;
        s1 = 1;
        while (r1 != 0)
        begin
            q  = r0 / r1;
            t  = r0 - q * r1;
            r0 = r1;
            r1 = t;
            t  = s0 - q * s1;
            s0 = s1;
            s1 = t;
        end
        s0 = s0 % $signed(m);
        if (s0 < 0)
            s0 = s0 + $signed(m);
        return $unsigned(s0);
    endfunction

    function automatic sri_res_t shared_range(
        input logic [CW-1:0] fa_in, input logic [CW-1:0] la_in, input logic [CW-1:0] sa_in,
        input logic [CW-1:0] fb_in, input logic [CW-1:0] lb_in, input logic [CW-1:0] sb_in);
        longint unsigned fa, la, sa, fb, lb, sb, t;
        longint unsigned g, sbg, lcm_v, r, d, k, x, maxf, minl, rem, gap, lo, hi;
        bit              none;
        sri_res_t        res;
        fa = fa_in;
        la = la_in;
        sa = sa_in;
        fb = fb_in;
        lb = lb_in;
        sb = sb_in;
        if (fa > la)
        begin
            t  = fa;
            fa = la;
            la = t;
        end
        if (fb > lb)
        begin
            t  = fb;
            fb = lb;
            lb = t;
        end
        if (sa == 0)
            sa = 1;
        if (sb == 0)
            sb = 1;
        lo    = 1;
        hi    = 0;
        none  = 1'b0;
        g     = gcd_of(sa, sb);
        sbg   = sb / g;
        lcm_v = sa * sbg;
        if ((fa % g) != (fb % g))
            none = 1'b1;
        else
        begin
            r    = fa % sa;
            d    = ((fb % sb) + sb - (r % sb)) % sb;
            k    = ((d / g) % sbg) * inverse_mod((sa / g) % sbg, sbg) % sbg;
            x    = r + sa * k;
            maxf = (fa > fb) ? fa : fb;
            minl = (la < lb) ? la : lb;
            if (minl < maxf)
                none = 1'b1;
            else if (x >= maxf)
            begin
                if (x > minl)
                    none = 1'b1;
                else
                    lo = x;
            end
            else
            begin
                rem = (maxf - x) % lcm_v;
                gap = (rem == 0) ? 0 : (lcm_v - rem);
                if (gap > minl - maxf)
                    none = 1'b1;
                else
                    lo = maxf + gap;
            end
            if (!none)
                hi = minl - ((minl - lo) % lcm_v);
        end
        if (none)
        begin
            lo = 1;
            hi = 0;
        end
        res.first  = lo[CW-1:0];
        res.last   = hi[CW-1:0];
        res.stride = (lcm_v > 64'hFFFF_FFFF) ? '1 : lcm_v[SW-1:0];
        res.empty  = none;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH result %0d: %s", $time, result_idx, msg);
        err_count = err_count + 1;
    endtask

    task automatic enqueue_expected(input sri_res_t item);
        shared_q.insert(shared_q.size(), item);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            err_count  = 0;
            pending    = 0;
            result_idx = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (shared_q.size() == 0)
                    report_mismatch("result transfer with nothing expected");
                else
                begin
                    want = shared_q.pop_front();
                    if (out_first !== want.first)
                        report_mismatch($sformatf("out_first got %0d want %0d",
                                                  out_first, want.first));
                    if (out_last !== want.last)
                        report_mismatch($sformatf("out_last got %0d want %0d",
                                                  out_last, want.last));
                    if (out_stride !== want.stride)
                        report_mismatch($sformatf("out_stride got %0d want %0d",
                                                  out_stride, want.stride));
                    if (is_empty !== want.empty)
                        report_mismatch($sformatf("is_empty got %0b want %0b",
                                                  is_empty, want.empty));
                end
                result_idx = result_idx + 1;
            end
            if (in_valid && in_ready)
                enqueue_expected(shared_range(first_a, last_a, stride_a,
                                              first_b, last_b, stride_b));
            pending = shared_q.size();
        end
    end

endmodule

### sim/tb.sv
// Testbench top: clock, reset, range stimulus, output stalls and the final verdict.
`timescale 1ns / 1ps
module tb;
    import sri_pkg::*;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_ready;
    logic [CW-1:0] first_a;
    logic [CW-1:0] last_a;
    logic [CW-1:0] stride_a;
    logic [CW-1:0] first_b;
    logic [CW-1:0] last_b;
    logic [CW-1:0] stride_b;
    logic          out_valid;
    logic          out_ready;
    logic [CW-1:0] out_first;
    logic [CW-1:0] out_last;
    logic [SW-1:0] out_stride;
    logic          is_empty;
    int            err_count;
    int            pending;

    int            burst_left;
    int            rx_mode;
    int            rx_phase_left;
    int            rx_stall_left;
    logic [7:0]    rx_pattern;

    strided_range_intersect u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .first_a    (first_a),
        .last_a     (last_a),
        .stride_a   (stride_a),
        .first_b    (first_b),
        .last_b     (last_b),
        .stride_b   (stride_b),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_first  (out_first),
        .out_last   (out_last),
        .out_stride (out_stride),
        .is_empty   (is_empty)
    );

    sri_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .first_a    (first_a),
        .last_a     (last_a),
        .stride_a   (stride_a),
        .first_b    (first_b),
        .last_b     (last_b),
        .stride_b   (stride_b),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_first  (out_first),
        .out_last   (out_last),
        .out_stride (out_stride),
        .is_empty   (is_empty),
        .err_count  (err_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    initial
    begin
        #(80_000_000);
        $display("end of test: mismatches");
        $finish;
    end

    // Output side: phases of always ready, random stalls, a rotating pattern or long stalls.
    initial
    begin
        out_ready     = 1'b0;
        rx_mode       = 0;
        rx_phase_left = 0;
        rx_stall_left = 0;
        rx_pattern    = 8'h5A;
        forever
        begin
            @(negedge clk);
            if (rx_phase_left == 0)
            begin
                rx_mode       = $urandom_range(0, 3);
                rx_phase_left = $urandom_range(50, 400);
                rx_pattern    = 8'($urandom_range(0, 255)) | 8'h01;
                rx_stall_left = 0;
            end
            rx_phase_left = rx_phase_left - 1;
            case (rx_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 3) != 0);
                2:
                begin
                    out_ready  <= rx_pattern[0];
                    rx_pattern  = {rx_pattern[0], rx_pattern[7:1]};
                end
                default:
                begin
                    if (rx_stall_left > 0)
                    begin
                        out_ready    <= 1'b0;
                        rx_stall_left = rx_stall_left - 1;
                    end
                    else
                    begin
                        out_ready <= 1'b1;
                        if ($urandom_range(0, 63) == 0)
                            rx_stall_left = $urandom_range(20, 700);
                    end
                end
            endcase
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_ranges(
        input logic [CW-1:0] fa, input logic [CW-1:0] la, input logic [CW-1:0] sa,
        input logic [CW-1:0] fb, input logic [CW-1:0] lb, input logic [CW-1:0] sb);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 600) : $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        in_valid <= 1'b1;
        first_a  <= fa;
        last_a   <= la;
        stride_a <= sa;
        first_b  <= fb;
        last_b   <= lb;
        stride_b <= sb;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        burst_left = burst_left - 1;
    endtask

    task automatic make_ranges(
        output logic [CW-1:0] fa, output logic [CW-1:0] la, output logic [CW-1:0] sa,
        output logic [CW-1:0] fb, output logic [CW-1:0] lb, output logic [CW-1:0] sb);
        int unsigned kind;
        int unsigned g;
        int unsigned base_a;
        int unsigned base_b;
        logic [CW-1:0] t;
        kind = $urandom_range(0, 99);
        if (kind < 50)
        begin
            // matching residues with windows that start close together
            g      = $urandom_range(1, 16);
            sa     = CW'(g * $urandom_range(1, 40));
            sb     = CW'(g * $urandom_range(1, 40));
            base_a = $urandom_range(0, 30000);
            base_b = base_a + g * $urandom_range(0, 200);
            fa     = CW'(base_a);
            fb     = CW'(base_b);
            la     = CW'(base_a + $urandom_range(0, 30000));
            lb     = CW'(base_b + $urandom_range(0, 30000));
        end
        else if (kind < 70)
        begin
            fa = CW'($urandom_range(0, 65535));
            la = CW'($urandom_range(0, 65535));
            sa = CW'($urandom_range(1, 65535));
            fb = CW'($urandom_range(0, 65535));
            lb = CW'($urandom_range(0, 65535));
            sb = CW'($urandom_range(1, 65535));
        end
        else if (kind < 85)
        begin
            // random strides across nearly the whole coordinate space
            sa = CW'($urandom_range(1, 65535));
            sb = CW'($urandom_range(1, 65535));
            fa = CW'($urandom_range(0, 255));
            fb = CW'($urandom_range(0, 255));
            la = CW'(65535 - $urandom_range(0, 255));
            lb = CW'(65535 - $urandom_range(0, 255));
        end
        else
        begin
            // residues that disagree mod the shared factor
            g      = $urandom_range(2, 16);
            sa     = CW'(g * $urandom_range(1, 40));
            sb     = CW'(g * $urandom_range(1, 40));
            base_a = $urandom_range(0, 30000);
            base_b = base_a + g * $urandom_range(0, 200) + $urandom_range(1, g - 1);
            fa     = CW'(base_a);
            fb     = CW'(base_b);
            la     = CW'(base_a + $urandom_range(0, 30000));
            lb     = CW'(base_b + $urandom_range(0, 30000));
        end
        if ($urandom_range(0, 1))
        begin
            t  = fa;
            fa = la;
            la = t;
        end
        if ($urandom_range(0, 1))
        begin
            t  = fb;
            fb = lb;
            lb = t;
        end
    endtask

    initial
    begin
        logic [CW-1:0] fa, la, sa, fb, lb, sb;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        first_a    = '0;
        last_a     = '0;
        stride_a   = '0;
        first_b    = '0;
        last_b     = '0;
        stride_b   = '0;
        burst_left = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_ranges(16'd0,     16'd0,     16'd0,     16'd0,     16'd0,     16'd0);
        send_ranges(16'd0,     16'd65535, 16'd1,     16'd0,     16'd65535, 16'd1);
        send_ranges(16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535);
        send_ranges(16'd65535, 16'd0,     16'd1,     16'd100,   16'd50,    16'd3);
        send_ranges(16'd10,    16'd100,   16'd0,     16'd12,    16'd90,    16'd4);
        send_ranges(16'd5,     16'd900,   16'd6,     16'd7,     16'd800,   16'd0);
        send_ranges(16'd0,     16'd1000,  16'd4,     16'd1,     16'd1000,  16'd6);
        send_ranges(16'd0,     16'd100,   16'd97,    16'd50,    16'd60,    16'd1);
        send_ranges(16'd0,     16'd10,    16'd1,     16'd20,    16'd30,    16'd1);
        send_ranges(16'd0,     16'd65535, 16'd65521, 16'd0,     16'd65535, 16'd65519);
        send_ranges(16'd1,     16'd65535, 16'd65535, 16'd0,     16'd65535, 16'd65534);
        send_ranges(16'd3,     16'd60000, 16'd7,     16'd10,    16'd50000, 16'd7);
        send_ranges(16'd500,   16'd500,   16'd3,     16'd500,   16'd500,   16'd5);
        send_ranges(16'd5,     16'd1000,  16'd6,     16'd7,     16'd1000,  16'd10);
        send_ranges(16'd1,     16'd60000, 16'd3,     16'd30001, 16'd60000, 16'd5);
        send_ranges(16'd0,     16'd100,   16'd10,    16'd100,   16'd200,   16'd25);
        send_ranges(16'd0,     16'd65535, 16'd65535, 16'd65535, 16'd0,     16'd65535);
        send_ranges(16'd65535, 16'd0,     16'd2,     16'd1,     16'd65535, 16'd65534);
        send_ranges(16'd32768, 16'd65535, 16'd32768, 16'd0,     16'd32767, 16'd16384);
        send_ranges(16'd21845, 16'd43690, 16'd43690, 16'd43690, 16'd21845, 16'd21845);

        for (int n = 0; n < 650; n++)
        begin
            make_ranges(fa, la, sa, fb, lb, sb);
            send_ranges(fa, la, sa, fb, lb, sb);
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (600) @(negedge clk);
        if (err_count == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### files.f
rtl/core/sri_pkg.sv
rtl/core/sri_div.sv
rtl/core/sri_seq.sv
rtl/core/strided_range_intersect.sv
rtl/core/sri_checker.sv
sim/sri_checker.sv
sim/tb.sv
